// File: rtl/core/sjph_pkg.sv
// sjph_pkg: shared constants and types for the Shift-JIS aware path hash core.
// No dependencies; imported by every module of the core.

package sjph_pkg;

  // Default limit of the path buffer in bytes.
  localparam int unsigned BUFFER_BYTES_DEF = 4096;

  // Hash step multiplier; a constant product reduces to a shift-add tree.
  localparam logic [63:0] HASH_MULT = 64'd104729;

  // Shift-JIS lead byte ranges (code page 932).
  localparam logic [7:0] LEAD1_LO = 8'h81;
  localparam logic [7:0] LEAD1_HI = 8'h9F;
  localparam logic [7:0] LEAD2_LO = 8'hE0;
  localparam logic [7:0] LEAD2_HI = 8'hFC;

  // ASCII folding constants.
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] BACKSLASH  = 8'h5C;
  localparam logic [7:0] SLASH      = 8'h2F;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_HASH_SEED = 1'b0;  // register index, taken from paddr[2]

  // One path byte as it travels from the input register to the hash unit.
  typedef struct packed {
    logic [7:0] path_byte;
    logic       last_byte;
  } sjph_item_t;

endpackage

// File: rtl/core/sjph_in_reg.sv
// sjph_in_reg: input register stage of the path hash core.
// Depends on sjph_pkg for the item type.

module sjph_in_reg
  import sjph_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sjph_item_t in_item,
  output logic       item_valid,
  output sjph_item_t item,
  input  logic       item_take
);

  logic       valid_r;
  logic       valid_nxt;
  sjph_item_t item_r;

  // The stage refills in the same cycle that the hash unit takes its item.
  assign in_ready  = !valid_r || item_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/sjph_hash_unit.sv
// sjph_hash_unit: byte folding, 64-bit accumulator, length counter and result register.
// Depends on sjph_pkg for constants and the item type.

module sjph_hash_unit
  import sjph_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] hash_seed,
  input  logic        item_valid,
  input  sjph_item_t  item,
  output logic        item_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash,
  output logic        out_ok
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES);

  logic [63:0]      acc_r;
  logic [63:0]      acc_nxt;
  logic             trail_r;
  logic             trail_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [63:0]      out_hash_r;
  logic             out_ok_r;

  logic       is_lead;
  logic [7:0] hashed_byte;
  logic       path_ok;
  logic       out_free;

  // A last byte needs the result register; any other byte only updates state.
  assign out_free  = !out_valid_r || out_ready;
  assign item_take = item_valid && (!item.last_byte || out_free);

  assign is_lead = ((item.path_byte >= LEAD1_LO) && (item.path_byte <= LEAD1_HI)) ||
                   ((item.path_byte >= LEAD2_LO) && (item.path_byte <= LEAD2_HI));

  always_comb begin
    hashed_byte = item.path_byte;
    trail_nxt   = 1'b0;
    if (trail_r) begin
      trail_nxt = 1'b0;
    end else if (is_lead) begin
      trail_nxt = 1'b1;
    end else if ((item.path_byte >= LOWER_A) && (item.path_byte <= LOWER_Z)) begin
      hashed_byte = item.path_byte - CASE_DELTA;
    end else if (item.path_byte == BACKSLASH) begin
      hashed_byte = SLASH;
    end
  end

  // Byte is sign-extended, seed zero-extended; everything wraps at 64 bits.
  assign acc_nxt = (acc_r * HASH_MULT) + {{56{hashed_byte[7]}}, hashed_byte} +
                   {32'd0, hash_seed};

  assign cnt_nxt = (cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  assign path_ok = (cnt_nxt != CNT_MAX);

  assign out_valid_nxt = (item_take && item.last_byte) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 64'd0;
      trail_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        if (item.last_byte) begin
          acc_r   <= 64'd0;
          trail_r <= 1'b0;
          cnt_r   <= '0;
        end else begin
          acc_r   <= acc_nxt;
          trail_r <= trail_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last_byte) begin
      out_hash_r <= path_ok ? acc_nxt : 64'd0;
      out_ok_r   <= path_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;
  assign out_ok    = out_ok_r;

endmodule

// File: rtl/core/sjis_aware_path_hash_core.sv
// sjis_aware_path_hash_core: top level of the Shift-JIS aware path hash.
// Depends on sjph_pkg, sjph_in_reg and sjph_hash_unit.
//
//   Channel  Direction  Handshake        Payload
//   in_      slave      tvalid/tready    tdata = path_byte, tlast = last_byte
//   out_     master     tvalid/tready    tdata = hash_value, tuser = path_ok
//   cfg_     APB slave  psel/penable     register 0 (addr 0x0) = hash_seed
//
// One item is accepted per cycle unless a last item waits on a full result register.
// Each item is held in the input register until the hash unit takes it; a last byte
// then moves into the result register, from which its result is presented. The
// accumulator update (constant multiply, two adds) is the feedback loop that sets
// this rate. Reset is synchronous and clears all path state and the seed.
// A stalled result holds only items marked last; other items keep flowing
// until a last item meets a full result register.

module sjis_aware_path_hash_core
  import sjph_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] path_byte
  input  logic                  in_tlast,    // last_byte
  // Result items.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,   // [63:0] hash_value
  output logic [0:0]            out_tuser,   // [0] path_ok
  // Configuration.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [31:0] seed_r;
  logic        cfg_wr;
  logic        sel_seed;

  sjph_item_t  in_item;
  sjph_item_t  item;
  logic        item_valid;
  logic        item_take;
  logic        out_ok;

  // The register index is taken from the word address bit; byte lanes are ignored.
  assign sel_seed   = (cfg_paddr[2] == REG_HASH_SEED);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = sel_seed ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_wr && sel_seed) begin
      seed_r <= cfg_pwdata;
    end
  end

  assign in_item.path_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  sjph_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  sjph_hash_unit #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_hash_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .hash_seed  (seed_r),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_hash   (out_tdata),
    .out_ok     (out_ok)
  );

  assign out_tuser = out_ok;

endmodule

// File: rtl/core/sjph_checker.sv
// sjph_checker: port-level assertions for sjis_aware_path_hash_core.
// Depends on sjph_pkg; bound to the top level at the end of this file.

module sjph_checker
  import sjph_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [63:0]           out_tdata,
  input logic [0:0]            out_tuser,
  input logic                  cfg_pready
);

  // A result waiting on the sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  // An overlong path reports a zero hash.
  a_bad_path_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 64'd0))
    else $error("invalid path with nonzero hash");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The configuration port never inserts wait states.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind sjis_aware_path_hash_core sjph_checker u_sjph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// File: dv/tb_top.sv
// tb_top: self-checking testbench for sjis_aware_path_hash_core, streaming path bytes in and
// comparing every hash result against an in-bench predictor. Depends on sjph_pkg and the core.

module tb_top
  import sjph_pkg::*;
;

  // The core is built with its default buffer limit, stated here so the predictor agrees.
  localparam int unsigned PATH_LIMIT = 4096;

  // Hash arithmetic and byte classes used by the predictor and the stimulus.
  localparam logic [63:0] STEP_MULT    = 64'd104729;
  localparam logic [7:0]  LEAD_A_LO    = 8'h81;
  localparam logic [7:0]  LEAD_A_HI    = 8'h9F;
  localparam logic [7:0]  LEAD_B_LO    = 8'hE0;
  localparam logic [7:0]  LEAD_B_HI    = 8'hFC;
  localparam logic [7:0]  CH_LOWER_A   = 8'h61;
  localparam logic [7:0]  CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0]  CH_UPPER_A   = 8'h41;
  localparam logic [7:0]  CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0]  CASE_FOLD    = 8'h20;
  localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CH_SLASH     = 8'h2F;

  // Register map: the seed is register 0 at byte address 0.
  localparam logic [CFG_ADDR_W-1:0] SEED_ADDR = '0;

  // Settling time after a drain, before the next seed write.
  localparam int SETTLE_CYCLES = 6;
  // Ceiling on the run in time units, far beyond the slowest legal run.
  localparam int RUN_LIMIT = 6_000_000;
  // Minimum items per random phase.
  localparam int PHASE_ITEMS = 95;

  typedef struct {
    logic [7:0] path_byte;
    logic       last_byte;
  } path_item_t;

  typedef struct {
    logic [63:0] hash_value;
    logic        path_ok;
  } path_hash_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;     // [7:0] path_byte
  logic                  in_tlast = 1'b0;   // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [63:0]           out_tdata;         // [63:0] hash_value
  logic [0:0]            out_tuser;         // [0] path_ok
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  sjis_aware_path_hash_core #(
    .BUFFER_BYTES(PATH_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Path bytes waiting for the driver, and hashes waiting for the result channel.
  path_item_t path_bytes_q[$];
  path_hash_t pending_hashes[$];

  // Predictor state: a private copy of the seed and of the per-path hash state.
  logic [31:0] seed_cur = '0;
  logic [63:0] path_acc = '0;
  logic        trail_due = 1'b0;
  int unsigned path_len = 0;

  int mismatch_count = 0;

  function automatic bit is_lead_byte(input logic [7:0] b);
    return (b >= LEAD_A_LO && b <= LEAD_A_HI) || (b >= LEAD_B_LO && b <= LEAD_B_HI);
  endfunction

  // Folds one accepted byte into the running path hash. The byte after a lead byte is
  // taken raw and never opens a pair of its own; other bytes are upper-cased and have
  // backslash turned into slash. A last byte closes the path and queues its hash.
  function automatic void fold_and_hash(input logic [7:0] b, input logic last);
    logic [7:0] h;
    path_hash_t r;
    h = b;
    if (trail_due) begin
      trail_due = 1'b0;
    end else if (is_lead_byte(b)) begin
      trail_due = 1'b1;
    end else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
      h = b - CASE_FOLD;
    end else if (b == CH_BACKSLASH) begin
      h = CH_SLASH;
    end
    path_acc = path_acc * STEP_MULT + {{56{h[7]}}, h} + {32'd0, seed_cur};
    if (path_len < PATH_LIMIT) path_len++;
    if (last) begin
      r.path_ok      = (path_len <= PATH_LIMIT - 1);
      r.hash_value   = r.path_ok ? path_acc : '0;
      pending_hashes = {pending_hashes, r};
      path_acc  = '0;
      trail_due = 1'b0;
      path_len  = 0;
    end
  endfunction

  // Idle lengths: none in a steady stretch, otherwise mostly short with a few long ones.
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver. An item stays on the bus until it is taken; the accepted item is handed to
  // the predictor at the same edge, using the values that were on the bus before it.
  int in_gap = 0;
  bit in_steady = 1'b0;
  bit in_next_valid;
  path_item_t in_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      in_next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        fold_and_hash(in_tdata, in_tlast);
        in_next_valid = 1'b0;
      end
      if (!in_next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (path_bytes_q.size() > 0) begin
          in_item = path_bytes_q.pop_front();
          in_tdata <= in_item.path_byte;
          in_tlast <= in_item.last_byte;
          in_next_valid = 1'b1;
          if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
          in_gap = pick_gap(in_steady);
        end
      end
      in_tvalid <= in_next_valid;
    end
  end

  // Monitor. Every accepted result is matched against the oldest predicted hash, and
  // the ready line is dropped for random stretches so stalls hit every phase of the core.
  int out_stall = 0;
  bit out_steady = 1'b0;
  path_hash_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_hashes.size() == 0) begin
          $display("%0t: result with nothing expected: hash_value %h path_ok %b",
                   $time, out_tdata, out_tuser[0]);
          mismatch_count++;
        end else begin
          want = pending_hashes.pop_front();
          if (out_tdata !== want.hash_value) begin
            $display("%0t: hash_value expected %h actual %h",
                     $time, want.hash_value, out_tdata);
            mismatch_count++;
          end
          if (out_tuser[0] !== want.path_ok) begin
            $display("%0t: path_ok expected %b actual %b",
                     $time, want.path_ok, out_tuser[0]);
            mismatch_count++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) out_steady = !out_steady;
      if (out_stall == 0) out_stall = pick_gap(out_steady);
      else out_stall--;
      out_tready <= (out_stall == 0);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic last);
    path_item_t it;
    it.path_byte = b;
    it.last_byte = last;
    path_bytes_q = {path_bytes_q, it};
  endtask

  // Writes the seed through a setup and an access cycle, then updates the predictor
  // and checks that the register reads back the new value.
  task automatic write_seed(input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SEED_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    seed_cur = value;
    @(negedge clk);
    if (cfg_prdata !== value) begin
      $display("%0t: hash_seed read expected %h actual %h", $time, value, cfg_prdata);
      mismatch_count++;
    end
  endtask

  // Waits at falling edges, where every update of the rising edge has settled, until all
  // items are taken and all hashes have come back, then lets the pipeline run dry.
  task automatic drain();
    do @(negedge clk);
    while (path_bytes_q.size() != 0 || in_tvalid || pending_hashes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hand-picked paths: case folding at the letter boundaries, backslash, a lead byte that
  // ends its path, trail bytes taken raw (including one inside a lead range), bytes just
  // outside the lead ranges, the sign bit, and a zero byte at the start of a path.
  task automatic queue_directed();
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h7A, 1'b0);
    queue_byte(8'h60, 1'b0);
    queue_byte(8'h7B, 1'b0);
    queue_byte(CH_UPPER_A, 1'b0);
    queue_byte(CH_UPPER_Z, 1'b0);
    queue_byte(CH_BACKSLASH, 1'b0);
    queue_byte(CH_SLASH, 1'b1);
    queue_byte(LEAD_A_LO, 1'b1);
    queue_byte(LEAD_B_HI, 1'b0);
    queue_byte(CH_BACKSLASH, 1'b0);
    queue_byte(LEAD_A_HI, 1'b0);
    queue_byte(CH_LOWER_A, 1'b0);
    queue_byte(LEAD_B_LO, 1'b0);
    queue_byte(LEAD_A_LO, 1'b0);
    queue_byte(CH_LOWER_A, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hDF, 1'b0);
    queue_byte(8'hFD, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b1);
    // A lead byte closing one path must not turn the next path's first byte into a trail.
    queue_byte(LEAD_B_LO, 1'b1);
    queue_byte(CH_LOWER_Z, 1'b1);
  endtask

  // Queues one path. Plain paths look like real archive names: letters of both cases,
  // separators, half-width katakana and well-formed two-byte characters, with an odd
  // lead byte left dangling at the end now and then. Noise paths are arbitrary bytes.
  task automatic queue_path(input int len, input bit noise);
    logic [7:0] b;
    bit pair_open;
    pair_open = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        b = 8'($urandom_range(0, 255));
      end else if (pair_open) begin
        b = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(8'h40, 8'hFC));
        pair_open = 1'b0;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: begin
            b = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
          end
          2: begin
            b = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
          end
          3: begin
            b = ($urandom_range(0, 1) == 0) ? CH_BACKSLASH : CH_SLASH;
          end
          4: begin
            b = 8'(($urandom_range(0, 1) == 0) ? $urandom_range(LEAD_A_LO, LEAD_A_HI)
                                               : $urandom_range(LEAD_B_LO, LEAD_B_HI));
            pair_open = 1'b1;
          end
          5: begin
            b = 8'($urandom_range(8'h20, 8'h7F));
          end
          6: begin
            b = 8'($urandom_range(8'hA1, 8'hDF));
          end
          default: begin
            b = 8'($urandom_range(0, 255));
            pair_open = is_lead_byte(b);
          end
        endcase
      end
      queue_byte(b, i == len - 1);
    end
  endtask

  task automatic random_phase(input logic [31:0] seed);
    int queued;
    int len;
    bit noise;
    write_seed(seed);
    queued = 0;
    while (queued < PHASE_ITEMS) begin
      noise = ($urandom_range(0, 99) < 15);
      if (noise) len = $urandom_range(1, 8);
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(21, 60);
      else len = $urandom_range(1, 20);
      queue_path(len, noise);
      queued += len;
    end
    drain();
  endtask

  // Sequencer: reset once, then directed and random phases under changing seeds, each fully drained before
  // the seed changes so no write ever lands while a path is in flight.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_seed(32'h0000_0000);
    queue_directed();
    drain();
    write_seed(32'hFFFF_FFFF);
    queue_directed();
    drain();

    random_phase($urandom);
    random_phase(32'h0000_0001);
    random_phase(32'h8000_0000);
    random_phase(32'hFFFF_FFFF);
    random_phase(32'h0000_0000);
    random_phase($urandom);

    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sjph_pkg.sv
rtl/core/sjph_in_reg.sv
rtl/core/sjph_hash_unit.sv
rtl/core/sjis_aware_path_hash_core.sv
rtl/core/sjph_checker.sv
dv/tb_top.sv
